// ===== rtl/ttid_pkg.sv =====
package ttid_pkg;

  // Longest bool word kept for matching
  localparam int WORD_MAX = 5;
  localparam int WLEN_W   = $clog2(WORD_MAX + 1);
  // Longest bool literal ("false")
  localparam int LIT_MAX  = 5;

  // Bool literal, right aligned, first char in the highest used byte
  typedef logic [8*LIT_MAX-1:0] lit_t;

  // Largest magnitude that can still take one more digit without 64-bit overflow
  localparam logic [63:0] MAG_LIMIT = 64'd1844674407370955161;

  // Target type codes
  localparam logic [3:0] TT_INT64  = 4'd0;
  localparam logic [3:0] TT_INT32  = 4'd1;
  localparam logic [3:0] TT_INT16  = 4'd2;
  localparam logic [3:0] TT_INT8   = 4'd3;
  localparam logic [3:0] TT_UINT64 = 4'd4;
  localparam logic [3:0] TT_UINT32 = 4'd5;
  localparam logic [3:0] TT_UINT16 = 4'd6;
  localparam logic [3:0] TT_UINT8  = 4'd7;
  localparam logic [3:0] TT_BOOL   = 4'd8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TYPE,
    CFG_DEFAULT_VALUE,
    CFG_DEFAULT_IS_NULL,
    CFG_DEFAULT_NULL_REASON
  } cfg_idx_t;

  // Integer parse phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  // How a text value ended
  typedef enum logic [1:0] {
    END_TEXT,
    END_EMPTY,
    END_NULL
  } end_kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
    logic       empty_record;
    logic       null_record;
    logic [6:0] null_reason_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        result_null;
    logic [6:0]  null_reason_out;
    logic        used_default;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  target_type;
    logic [63:0] default_value;
    logic        default_is_null;
    logic [6:0]  default_null_reason;
  } cfg_t;

  // Running parse state of one text value
  typedef struct packed {
    phase_t                      phase;
    logic                        at_start;
    logic                        negative;
    logic [63:0]                 magnitude;
    logic                        overflowed;
    logic                        dash_seen;
    logic [WORD_MAX-1:0][7:0]    word_chars;
    logic [WLEN_W-1:0]           word_length;
    logic                        word_closed;
    logic                        ended;
    logic                        word_bad;
  } parse_t;

  // Final state of a value handed to the converter
  typedef struct packed {
    end_kind_t  kind;
    logic [6:0] reason;
    parse_t     ps;
  } snap_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

  // Compare the collected word with a literal of n characters, first char in the high byte
  function automatic logic word_eq(input logic [WORD_MAX-1:0][7:0] chars,
                                   input logic [WLEN_W-1:0] len,
                                   input logic bad,
                                   input lit_t lit,
                                   input int n);
    logic eq;
    eq = !bad && (len == WLEN_W'(n));
    for (int i = 0; i < LIT_MAX; i++) begin
      if (i < n) begin
        if (chars[i] != lit[8*(n-1-i) +: 8]) begin
          eq = 1'b0;
        end
      end
    end
    return eq;
  endfunction

endpackage

// ===== rtl/ttid_parse.sv =====
module ttid_parse import ttid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     proc,
  input  in_item_t item,
  input  logic     snap_take,
  output logic     snap_v,
  output snap_t    snap
);

  parse_t ps;
  parse_t ps_next;
  logic   ending;
  logic   digit;
  logic   ws;
  logic [7:0] c;
  end_kind_t kind;

  assign c      = item.char_in;
  assign ending = item.last || item.empty_record || item.null_record;
  assign digit  = c inside {[8'h30:8'h39]};
  assign ws     = is_ws(c);

  always_comb begin
    if (item.null_record) begin
      kind = END_NULL;
    end else if (item.empty_record) begin
      kind = END_EMPTY;
    end else begin
      kind = END_TEXT;
    end
  end

  // One byte applied to the parse state
  always_comb begin
    ps_next = ps;
    if (!ps.ended) begin
      if (c == 8'd0) begin
        ps_next.ended = 1'b1;
      end else begin
        ps_next.at_start = 1'b0;
        if (c == 8'h2D) begin
          ps_next.dash_seen = 1'b1;
        end

        // integer grammar
        case (ps.phase)
          PH_LEAD: begin
            if (!ws) begin
              if (c == 8'h2B || c == 8'h2D) begin
                ps_next.negative = (c == 8'h2D);
                ps_next.phase    = PH_SIGN;
              end else begin
                ps_next.phase = digit ? PH_DIGITS : PH_BAD;
              end
            end
          end
          PH_SIGN: begin
            ps_next.phase = digit ? PH_DIGITS : PH_BAD;
          end
          PH_DIGITS: begin
            if (ws) begin
              ps_next.phase = PH_TRAIL;
            end else if (!digit) begin
              ps_next.phase = PH_BAD;
            end
          end
          PH_TRAIL: begin
            if (!ws) begin
              ps_next.phase = PH_BAD;
            end
          end
          default: begin
            ps_next.phase = PH_BAD;
          end
        endcase

        // magnitude accumulate, times ten by shift-add
        if (digit && ps_next.phase == PH_DIGITS && !ps.overflowed) begin
          if (ps.magnitude > MAG_LIMIT || (ps.magnitude == MAG_LIMIT && c[3:0] > 4'd5)) begin
            ps_next.overflowed = 1'b1;
          end else begin
            ps_next.magnitude = {ps.magnitude[60:0], 3'b000} + {ps.magnitude[62:0], 1'b0}
                              + {60'd0, c[3:0]};
          end
        end

        // bool word collection
        if (ws) begin
          if (ps.word_length != '0) begin
            ps_next.word_closed = 1'b1;
          end
        end else if (ps.word_closed || ps.word_length >= WLEN_W'(WORD_MAX)) begin
          ps_next.word_bad = 1'b1;
        end else begin
          for (int i = 0; i < WORD_MAX; i++) begin
            if (ps.word_length == WLEN_W'(i)) begin
              ps_next.word_chars[i] = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
            end
          end
          ps_next.word_length = ps.word_length + 1'b1;
        end
      end
    end
  end

  // Parse state; cleared at each end of value
  always_ff @(posedge clk) begin
    if (rst) begin
      ps.phase       <= PH_LEAD;
      ps.at_start    <= 1'b1;
      ps.negative    <= 1'b0;
      ps.magnitude   <= '0;
      ps.overflowed  <= 1'b0;
      ps.dash_seen   <= 1'b0;
      ps.word_length <= '0;
      ps.word_closed <= 1'b0;
      ps.ended       <= 1'b0;
      ps.word_bad    <= 1'b0;
    end else if (proc) begin
      if (ending) begin
        ps.phase       <= PH_LEAD;
        ps.at_start    <= 1'b1;
        ps.negative    <= 1'b0;
        ps.magnitude   <= '0;
        ps.overflowed  <= 1'b0;
        ps.dash_seen   <= 1'b0;
        ps.word_length <= '0;
        ps.word_closed <= 1'b0;
        ps.ended       <= 1'b0;
        ps.word_bad    <= 1'b0;
      end else begin
        ps <= ps_next;
      end
    end
  end

  // Snapshot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_v <= 1'b0;
    end else if (proc && ending) begin
      snap_v <= 1'b1;
    end else if (snap_take) begin
      snap_v <= 1'b0;
    end
  end

  // Snapshot payload
  always_ff @(posedge clk) begin
    if (proc && ending) begin
      snap.kind   <= kind;
      snap.reason <= item.null_reason_in;
      snap.ps     <= ps_next;
    end
  end

endmodule

// ===== rtl/ttid_conv.sv =====
module ttid_conv import ttid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  logic      out_free,
  input  snap_t     snap,
  input  cfg_t      cfg,
  output logic      out_v,
  output out_item_t result
);

  logic [3:0]  t;
  logic [63:0] mag;
  logic [63:0] dv;
  logic [63:0] pos_max;
  logic [63:0] neg_max;
  logic [63:0] conv_val;
  logic [63:0] shaped_dv;
  logic        in_range;
  logic        is_false;
  logic        is_true;
  logic        ok;
  out_item_t   res_next;

  assign t   = cfg.target_type;
  assign mag = snap.ps.magnitude;
  assign dv  = cfg.default_value;

  // Range limits per integer type
  always_comb begin
    case (t)
      TT_INT64: begin
        pos_max = 64'h7FFF_FFFF_FFFF_FFFF;
        neg_max = 64'h8000_0000_0000_0000;
      end
      TT_INT32: begin
        pos_max = 64'h0000_0000_7FFF_FFFF;
        neg_max = 64'h0000_0000_8000_0000;
      end
      TT_INT16: begin
        pos_max = 64'h0000_0000_0000_7FFF;
        neg_max = 64'h0000_0000_0000_8000;
      end
      TT_INT8: begin
        pos_max = 64'h0000_0000_0000_007F;
        neg_max = 64'h0000_0000_0000_0080;
      end
      TT_UINT32: begin
        pos_max = 64'h0000_0000_FFFF_FFFF;
        neg_max = '0;
      end
      TT_UINT16: begin
        pos_max = 64'h0000_0000_0000_FFFF;
        neg_max = '0;
      end
      TT_UINT8: begin
        pos_max = 64'h0000_0000_0000_00FF;
        neg_max = '0;
      end
      default: begin
        pos_max = '1;
        neg_max = '0;
      end
    endcase
  end

  assign in_range = snap.ps.negative ? (mag <= neg_max) : (mag <= pos_max);
  assign conv_val = snap.ps.negative ? (64'd0 - mag) : mag;

  // Default cut to the target width and extended
  always_comb begin
    case (t)
      TT_INT64, TT_UINT64: shaped_dv = dv;
      TT_INT32:            shaped_dv = {{32{dv[31]}}, dv[31:0]};
      TT_INT16:            shaped_dv = {{48{dv[15]}}, dv[15:0]};
      TT_INT8:             shaped_dv = {{56{dv[7]}}, dv[7:0]};
      TT_UINT32:           shaped_dv = {32'd0, dv[31:0]};
      TT_UINT16:           shaped_dv = {48'd0, dv[15:0]};
      TT_UINT8:            shaped_dv = {56'd0, dv[7:0]};
      TT_BOOL:             shaped_dv = {63'd0, |dv[7:0]};
      default:             shaped_dv = dv;
    endcase
  end

  // Bool words
  assign is_false =
      word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("0"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("f"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("n"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("no"), 2)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("false"), 5);
  assign is_true =
      word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("1"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("t"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("y"), 1)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("yes"), 3)
   || word_eq(snap.ps.word_chars, snap.ps.word_length, snap.ps.word_bad, lit_t'("true"), 4);

  // Conversion outcome
  always_comb begin
    res_next = '0;
    ok       = 1'b0;
    if (snap.kind == END_NULL) begin
      res_next.result_null     = 1'b1;
      res_next.null_reason_out = snap.reason;
      ok                       = 1'b1;
    end else if (snap.kind == END_TEXT) begin
      if (t == TT_BOOL) begin
        ok                  = is_false || is_true;
        res_next.value_bits = {63'd0, !is_false};
      end else if (t > TT_BOOL || snap.ps.at_start) begin
        ok = 1'b0;
      end else if (snap.ps.phase == PH_SIGN || snap.ps.phase == PH_BAD) begin
        ok = 1'b0;
      end else if (snap.ps.phase == PH_LEAD) begin
        ok = 1'b1;
      end else if (snap.ps.overflowed) begin
        ok = 1'b0;
      end else if (t == TT_UINT64 && snap.ps.dash_seen) begin
        ok = 1'b0;
      end else begin
        ok                  = in_range;
        res_next.value_bits = conv_val;
      end
    end

    if (!ok) begin
      res_next.used_default = 1'b1;
      if (cfg.default_is_null) begin
        res_next.value_bits      = '0;
        res_next.result_null     = 1'b1;
        res_next.null_reason_out = cfg.default_null_reason;
      end else begin
        res_next.value_bits      = shaped_dv;
        res_next.result_null     = 1'b0;
        res_next.null_reason_out = '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load) begin
      out_v <= 1'b1;
    end else if (out_free) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/text_to_integer_with_default_unit.sv =====
// Path: a value's final item passes the input register, then the snapshot register, then
// the result register, which drives result_valid.
// Throughput: one text byte per cycle; a final byte may stall only while both the
// snapshot and the result register are held by an unaccepted result.
// Reset (rst, synchronous): clears all valid flags, parse state and the four
// configuration registers; no clearing pass.
module text_to_integer_with_default_unit import ttid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  in_item_t             text_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output out_item_t            result
);

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_v;
  logic     ending;
  logic     proc;
  logic     snap_v;
  logic     snap_take;
  logic     out_free;
  snap_t    snap;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_TYPE:         cfg.target_type         <= cfg_wdata[3:0];
        CFG_DEFAULT_VALUE:       cfg.default_value       <= cfg_wdata;
        CFG_DEFAULT_IS_NULL:     cfg.default_is_null     <= cfg_wdata[0];
        CFG_DEFAULT_NULL_REASON: cfg.default_null_reason <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes
  assign out_free   = !result_valid || !result_stall;
  assign snap_take  = snap_v && out_free;
  assign ending     = in_item.last || in_item.empty_record || in_item.null_record;
  assign proc       = in_v && (!ending || !snap_v || snap_take);
  assign text_stall = in_v && !proc;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_v <= 1'b1;
    end else if (proc) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_item <= text_item;
    end
  end

  ttid_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .proc      (proc),
    .item      (in_item),
    .snap_take (snap_take),
    .snap_v    (snap_v),
    .snap      (snap)
  );

  ttid_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .load     (snap_take),
    .out_free (out_free),
    .snap     (snap),
    .cfg      (cfg),
    .out_v    (result_valid),
    .result   (result)
  );

endmodule

// ===== rtl/ttid_check.sv =====
module ttid_check import ttid_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 text_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input out_item_t            result
);

  // A stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !text_stall)
    else $error("not idle after reset");

  // Null results carry zero value bits
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_null |-> result.value_bits == 64'd0)
    else $error("null result with nonzero value");

  // Non-null results carry no reason
  a_reason_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.result_null |-> result.null_reason_out == 7'd0)
    else $error("reason on non-null result");

endmodule

bind text_to_integer_with_default_unit ttid_check u_check (.*);

// ===== bench/text_to_integer_with_default_unit_tb.sv =====
`timescale 1ns / 100ps

module text_to_integer_with_default_unit_tb;
  import ttid_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASE_ITEMS  = 130;
  localparam int CALM_TAIL    = 250;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [63:0] TEN_LIMIT = 64'd1844674407370955161;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  cfg_idx_t   cfg_index;
  logic [63:0] cfg_wdata;
  logic       text_valid;
  logic       text_stall;
  in_item_t   text_item;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_item_t  result;

  text_to_integer_with_default_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [3:0]  cur_type;
  logic [63:0] cur_default;
  logic        cur_default_null;
  logic [6:0]  cur_null_reason;

  // Shadow parse state of the value in flight
  phase_t      num_phase;
  logic        at_start;
  logic        is_negative;
  logic [63:0] magnitude;
  logic        mag_overflow;
  logic        saw_dash;
  logic [7:0]  word_chars [WORD_MAX];
  int          word_len;
  logic        word_closed;
  logic        text_ended;
  logic        word_bad;

  out_item_t   expected_results[$];
  out_item_t   want;
  logic [7:0]  text_buf[$];

  int   errors = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   reg_writes = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  int   run_left = 0;
  logic idle_on = 1'b1;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_text_state();
    num_phase    = PH_LEAD;
    at_start     = 1'b1;
    is_negative  = 1'b0;
    magnitude    = '0;
    mag_overflow = 1'b0;
    saw_dash     = 1'b0;
    word_len     = 0;
    word_closed  = 1'b0;
    text_ended   = 1'b0;
    word_bad     = 1'b0;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int type_width(logic [3:0] t);
    case (t[1:0])
      2'd0: return 64;
      2'd1: return 32;
      2'd2: return 16;
      default: return 8;
    endcase
  endfunction

  // One text byte through the integer parse and the bool word collector
  function automatic void absorb_char(logic [7:0] c);
    logic digit;
    logic ws;
    logic [63:0] d;
    if (text_ended) return;
    if (c == 8'd0) begin
      text_ended = 1'b1;
      return;
    end
    at_start = 1'b0;
    if (c == "-") saw_dash = 1'b1;
    digit = c >= "0" && c <= "9";
    ws    = is_space(c);
    case (num_phase)
      PH_LEAD: begin
        if (!ws) begin
          if (c == "+" || c == "-") begin
            is_negative = (c == "-");
            num_phase = PH_SIGN;
          end else begin
            num_phase = digit ? PH_DIGITS : PH_BAD;
          end
        end
      end
      PH_SIGN: num_phase = digit ? PH_DIGITS : PH_BAD;
      PH_DIGITS: begin
        if (ws) num_phase = PH_TRAIL;
        else if (!digit) num_phase = PH_BAD;
      end
      PH_TRAIL: if (!ws) num_phase = PH_BAD;
      default: num_phase = PH_BAD;
    endcase
    if (digit && num_phase == PH_DIGITS && !mag_overflow) begin
      d = 64'(c - "0");
      if (magnitude > TEN_LIMIT || (magnitude == TEN_LIMIT && d > 64'd5))
        mag_overflow = 1'b1;
      else
        magnitude = magnitude * 64'd10 + d;
    end
    // bool word: one lower-case word of at most WORD_MAX chars
    if (ws) begin
      if (word_len > 0) word_closed = 1'b1;
    end else if (word_closed || word_len >= WORD_MAX) begin
      word_bad = 1'b1;
    end else begin
      word_chars[word_len] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      word_len++;
    end
  endfunction

  function automatic logic word_matches(string w);
    if (word_bad || w.len() != word_len || w.len() > WORD_MAX) return 1'b0;
    for (int i = 0; i < w.len(); i++)
      if (word_chars[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic convert_text(output logic [63:0] v);
    int b;
    logic [63:0] half;
    logic [63:0] top;
    v = '0;
    if (cur_type == TT_BOOL) begin
      if (word_matches("0") || word_matches("f") || word_matches("n") ||
          word_matches("no") || word_matches("false")) return 1'b1;
      if (word_matches("1") || word_matches("t") || word_matches("y") ||
          word_matches("yes") || word_matches("true")) begin
        v = 64'd1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (cur_type > TT_BOOL || at_start) return 1'b0;
    if (num_phase == PH_SIGN || num_phase == PH_BAD) return 1'b0;
    // whitespace only
    if (num_phase == PH_LEAD) return 1'b1;
    if (mag_overflow) return 1'b0;
    if (cur_type == TT_UINT64) begin
      if (saw_dash) return 1'b0;
      v = magnitude;
      return 1'b1;
    end
    b = type_width(cur_type);
    if (cur_type < TT_UINT64) begin
      half = 64'd1 << (b - 1);
      if (is_negative ? magnitude > half : magnitude > half - 64'd1) return 1'b0;
    end else begin
      top = (64'd1 << b) - 64'd1;
      if (is_negative ? magnitude != 0 : magnitude > top) return 1'b0;
    end
    v = is_negative ? 64'd0 - magnitude : magnitude;
    return 1'b1;
  endfunction

  function automatic logic [63:0] shaped_default();
    int b;
    logic [63:0] m;
    logic [63:0] v;
    if (cur_type == TT_BOOL) return (cur_default[7:0] != 0) ? 64'd1 : 64'd0;
    if (cur_type > TT_BOOL) return cur_default;
    b = type_width(cur_type);
    m = (b == 64) ? '1 : (64'd1 << b) - 64'd1;
    v = cur_default & m;
    if (cur_type < TT_UINT64 && v[b-1]) v = v | ~m;
    return v;
  endfunction

  // Returns 1 when this transaction ends a value, with the expected result
  function automatic logic predict_conversion(in_item_t it, output out_item_t r);
    logic [63:0] v;
    r = '0;
    if (it.null_record) begin
      r.result_null     = 1'b1;
      r.null_reason_out = it.null_reason_in;
      clear_text_state();
      return 1'b1;
    end
    if (it.empty_record) begin
      clear_text_state();
    end else begin
      absorb_char(it.char_in);
      if (!it.last) return 1'b0;
    end
    if (!it.empty_record && convert_text(v)) begin
      r.value_bits = v;
    end else begin
      r.used_default = 1'b1;
      if (cur_default_null) begin
        r.result_null     = 1'b1;
        r.null_reason_out = cur_null_reason;
      end else begin
        r.value_bits = shaped_default();
      end
    end
    clear_text_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(in_item_t it);
    out_item_t r;
    if (idle_on && $urandom_range(7, 0) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    items_sent++;
    if (predict_conversion(it, r)) expected_results.push_back(r);
  endtask

  task automatic send_char(logic [7:0] c, logic fin);
    in_item_t it;
    it.char_in        = c;
    it.last           = fin;
    it.empty_record   = 1'b0;
    it.null_record    = 1'b0;
    it.null_reason_in = 7'($urandom_range(127, 0));
    send_item(it);
  endtask

  task automatic send_marker(logic nul, logic emp, logic fin);
    in_item_t it;
    it.char_in        = 8'($urandom_range(255, 0));
    it.last           = fin;
    it.empty_record   = emp;
    it.null_record    = nul;
    it.null_reason_in = 7'($urandom_range(127, 0));
    send_item(it);
  endtask

  function automatic void load_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // Send the buffered text as one value; no bytes means an empty record
  task automatic send_value();
    int n;
    n = text_buf.size();
    if (n == 0) send_marker(1'b0, 1'b1, 1'b1);
    for (int i = 0; i < n; i++) send_char(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  task automatic send_text(string s);
    load_str(s);
    send_value();
  endtask

  task automatic drain_results();
    text_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // the block may still hold a byte that ends no value
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_TARGET_TYPE:         cur_type         = data[3:0];
      CFG_DEFAULT_VALUE:       cur_default      = data;
      CFG_DEFAULT_IS_NULL:     cur_default_null = data[0];
      CFG_DEFAULT_NULL_REASON: cur_null_reason  = data[6:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block idle; unused upper bits carry junk
  task automatic set_config(logic [3:0] t, logic [63:0] dflt, logic dnull, logic [6:0] why);
    logic [63:0] pad;
    drain_results();
    pad = {$urandom, $urandom};
    write_reg(CFG_TARGET_TYPE, {pad[63:4], t});
    write_reg(CFG_DEFAULT_VALUE, dflt);
    write_reg(CFG_DEFAULT_IS_NULL, {pad[63:1], dnull});
    write_reg(CFG_DEFAULT_NULL_REASON, {pad[63:7], why});
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- text builders

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(5, 0);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic void build_number();
    int k;
    int b;
    logic [63:0] v;
    string s;
    repeat ($urandom_range(2, 0)) text_buf.push_back(pick_space());
    k = $urandom_range(3, 0);
    if (k == 0) text_buf.push_back("-");
    else if (k == 1) text_buf.push_back("+");
    b = 8 << $urandom_range(3, 0);
    case ($urandom_range(7, 0))
      0, 1: s = $sformatf("%0d", $urandom_range(999, 0));
      2, 3: begin
        // around the signed range edge
        v = (64'd1 << (b - 1)) + 64'($urandom_range(2, 0)) - 64'd1;
        s = $sformatf("%0d", v);
      end
      4: begin
        // around the unsigned range edge
        v = (b == 64) ? '1 : (64'd1 << b) - 64'd1;
        v = v + 64'($urandom_range(2, 0)) - 64'd1;
        s = $sformatf("%0d", v);
      end
      5: s = $sformatf("%0d%0d", TEN_LIMIT, $urandom_range(9, 0));
      6: begin
        v = {$urandom, $urandom};
        s = $sformatf("%0d", v);
        if ($urandom_range(1, 0) == 1) s = {"00", s};
        if ($urandom_range(5, 0) == 0) s = {s, "7"};
      end
      default: s = "";
    endcase
    load_str(s);
    repeat ($urandom_range(2, 0)) text_buf.push_back(pick_space());
  endfunction

  function automatic void build_bool_word();
    string w;
    logic [7:0] c;
    repeat ($urandom_range(2, 0)) text_buf.push_back(pick_space());
    case ($urandom_range(12, 0))
      0: w = "0";
      1: w = "f";
      2: w = "n";
      3: w = "no";
      4: w = "false";
      5: w = "1";
      6: w = "t";
      7: w = "y";
      8: w = "yes";
      9: w = "true";
      10: w = "falsey";
      11: w = "ye";
      default: w = "";
    endcase
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(1, 0) == 1) c = c - 8'd32;
      text_buf.push_back(c);
    end
    repeat ($urandom_range(2, 0)) text_buf.push_back(pick_space());
  endfunction

  function automatic void build_native(logic foreign);
    if ((cur_type == TT_BOOL) ^ foreign) build_bool_word();
    else build_number();
  endfunction

  // Drop a zero byte, a stray byte or a second word into the text
  function automatic void corrupt_text();
    int pos;
    logic [7:0] c;
    pos = $urandom_range(text_buf.size(), 0);
    case ($urandom_range(2, 0))
      0: c = 8'd0;
      1: c = 8'($urandom_range(255, 0));
      default: begin
        text_buf.push_back(8'd32);
        c = 8'($urandom_range(57, 48));
        pos = text_buf.size();
      end
    endcase
    if (pos >= text_buf.size()) text_buf.push_back(c);
    else text_buf.insert(pos, c);
  endfunction

  task automatic random_value();
    int kind;
    logic nul;
    kind = $urandom_range(99, 0);
    text_buf.delete();
    if (kind < 55) begin
      build_native(1'b0);
    end else if (kind < 68) begin
      build_native(1'b1);
    end else if (kind < 78) begin
      repeat ($urandom_range(8, 1)) text_buf.push_back(8'($urandom_range(255, 0)));
    end else if (kind < 88) begin
      // a few bytes, then a null or empty record that drops them
      repeat ($urandom_range(3, 0)) send_char(8'($urandom_range(57, 43)), 1'b0);
      nul = $urandom_range(1, 0);
      send_marker(nul, nul ? 1'($urandom_range(1, 0)) : 1'b1, 1'($urandom_range(1, 0)));
      return;
    end else begin
      build_native(1'b0);
      corrupt_text();
    end
    send_value();
  endtask

  task automatic random_config(int phase_no);
    logic [3:0]  t;
    logic [63:0] d;
    logic [6:0]  why;
    if (phase_no <= TT_BOOL) t = 4'(phase_no);
    else if ($urandom_range(5, 0) == 0) t = 4'($urandom_range(4'hF, TT_BOOL + 1));
    else t = 4'($urandom_range(TT_BOOL, TT_INT64));
    case (phase_no < 2 ? phase_no : $urandom_range(5, 0))
      0: d = '1;
      1: d = '0;
      2: d = 64'h8000_0000_0000_0000;
      3: d = 64'h80;
      4: d = {$urandom, $urandom} & ~64'hFF;
      default: d = {$urandom, $urandom};
    endcase
    case ($urandom_range(2, 0))
      0: why = '0;
      1: why = '1;
      default: why = 7'($urandom_range(127, 0));
    endcase
    set_config(t, d, $urandom_range(3, 0) == 0, why);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_integer_bounds();
    set_config(TT_INT8, 64'h1FF, 1'b0, 7'd0);
    send_text(" -128 ");
    send_text("127");
    send_text("128");
    set_config(TT_UINT16, 64'h1_2345, 1'b0, 7'd0);
    send_text("65535");
    send_text("-0");
  endtask

  task automatic test_bool_words();
    set_config(TT_BOOL, 64'h100, 1'b0, 7'd0);
    send_text("YES");
    send_text(" f ");
    send_text("False");
    send_text("maybe");
    send_text("");
  endtask

  task automatic test_special_cases();
    set_config(TT_INT64, 64'h1234, 1'b1, 7'h7F);
    send_marker(1'b1, 1'b0, 1'b1);
    // null wins over empty, and ends the value without last
    send_marker(1'b1, 1'b1, 1'b0);
    send_marker(1'b0, 1'b1, 1'b1);
    send_text("   ");
    send_text("-");
    // bytes after a zero byte are ignored
    load_str("12");
    text_buf.push_back(8'd0);
    load_str("x");
    send_value();
    text_buf.push_back(8'd0);
    send_value();
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    send_marker(1'b0, 1'b1, 1'b0);
    set_config(TT_UINT64, '1, 1'b0, 7'd0);
    send_text("-0");
    send_text(" +7 ");
    set_config(4'hF, 64'hDEAD, 1'b0, 7'd0);
    send_text("5");
  endtask

  task automatic test_random_traffic();
    int goal;
    int phase_no;
    int phase_end;
    goal = items_sent + RANDOM_ITEMS;
    phase_no = 0;
    while (items_sent < goal) begin
      idle_on = (goal - items_sent) > CALM_TAIL;
      random_config(phase_no);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < goal) random_value();
      phase_no++;
    end
  endtask

  task automatic finish_run();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d text bytes, checked %0d results, made %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("over every target type, unused type codes, null and default paths.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------- processes

  // Result-side backpressure in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      result_stall <= 1'b0;
    end else if ($urandom_range(2, 0) == 0) begin
      stall_left = $urandom_range(18, 1) - 1;
      result_stall <= 1'b1;
    end else begin
      run_left = $urandom_range(60, 1);
      result_stall <= 1'b0;
    end
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (text_valid && !text_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: value_bits=%h result_null=%b",
               result.value_bits, result.result_null);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.value_bits !== want.value_bits) begin
          $error("value_bits: expected %h, got %h", want.value_bits, result.value_bits);
          errors++;
        end
        if (result.result_null !== want.result_null) begin
          $error("result_null: expected %b, got %b", want.result_null, result.result_null);
          errors++;
        end
        if (result.null_reason_out !== want.null_reason_out) begin
          $error("null_reason_out: expected %0d, got %0d",
                 want.null_reason_out, result.null_reason_out);
          errors++;
        end
        if (result.used_default !== want.used_default) begin
          $error("used_default: expected %b, got %b", want.used_default, result.used_default);
          errors++;
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= CFG_TARGET_TYPE;
    cfg_wdata  <= '0;
    text_valid <= 1'b0;
    text_item  <= '0;
    cur_type         = TT_INT64;
    cur_default      = '0;
    cur_default_null = 1'b0;
    cur_null_reason  = '0;
    clear_text_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_integer_bounds();
    test_bool_words();
    test_special_cases();
    test_random_traffic();
    finish_run();
  end

endmodule
